// File: hdl/depth_thickness_patch_smoother_defines.svh
// Assertion macros used by the depth/thickness smoother top level.
`ifndef DEPTH_THICKNESS_PATCH_SMOOTHER_DEFINES_SVH
`define DEPTH_THICKNESS_PATCH_SMOOTHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define DTPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DTPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define DTPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DTPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/dtps_pkg.sv
// Types, widths, pipeline stage map and constants of the depth/thickness smoother.
package dtps_pkg;

    // Field widths
    localparam int DEPTH_W   = 32;
    localparam int THICK_W   = 31;
    localparam int INF_W     = 16;
    localparam int INF_FRAC  = 8;
    localparam int PROD_W    = INF_W + THICK_W;
    localparam int BOUND_W   = PROD_W - INF_FRAC;
    localparam int NUM_NB    = 8;
    localparam int SUM1_W    = BOUND_W + 1;
    localparam int SUM2_W    = BOUND_W + 2;
    localparam int SUM_W     = BOUND_W + 3;
    localparam int CNT_W     = 4;
    localparam int MIN_VALID = 3;

    // Divider: remainder stays below the count (at most 8)
    localparam int DIV_BITS  = 4;
    localparam int DQ_W      = 32;
    localparam int DIV_STG   = DQ_W / DIV_BITS;
    localparam int REM_W     = 3;

    // Pipeline stage map
    localparam int STG_IN    = 1;
    localparam int STG_BND   = 2;
    localparam int STG_CLP   = 3;
    localparam int STG_T1    = 4;
    localparam int STG_T2    = 5;
    localparam int STG_SUM   = 6;
    localparam int STG_DIV0  = 7;
    localparam int STG_OUT   = STG_DIV0 + DIV_STG;
    localparam int NUM_STG   = STG_OUT;

    localparam logic [THICK_W-1:0] THICK_MAX         = '1;
    localparam logic [INF_W-1:0]   MIN_INFLATE_RESET = 16'd256;
    localparam logic [INF_W-1:0]   MAX_INFLATE_RESET = 16'd1024;
    localparam logic [CNT_W-1:0]   MIN_VALID_CNT     = CNT_W'(MIN_VALID);

    typedef logic signed [DEPTH_W-1:0] t_depth;
    typedef logic [THICK_W-1:0]        t_thick;
    typedef logic [INF_W-1:0]          t_inflate;
    typedef logic [BOUND_W-1:0]        t_bound;
    typedef logic [SUM_W-1:0]          t_sum;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic [NUM_STG:1]          t_stg_vec;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MIN_INFLATE = 1'b0,
        CFG_MAX_INFLATE = 1'b1
    } t_cfg_idx;

    // Divider working state: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DQ_W-1:0]  dq;
    } t_div;

endpackage

// File: hdl/dtps_lane.sv
// One neighbor lane: validity, absolute depth difference and clamp to the bounds.
module dtps_lane (
    input  logic              i_clk,
    input  dtps_pkg::t_stg_vec i_en,
    input  dtps_pkg::t_depth  i_center_depth,
    input  dtps_pkg::t_depth  i_nbr_depth,
    input  logic              i_inside,
    input  dtps_pkg::t_bound  i_lower,
    input  dtps_pkg::t_bound  i_upper,
    output dtps_pkg::t_bound  o_clamp,
    output logic              o_vld
);

    logic [dtps_pkg::DEPTH_W:0]   delta;
    logic [dtps_pkg::DEPTH_W:0]   mag;
    logic [dtps_pkg::THICK_W-1:0] r_diff;
    logic                         r_nv;
    dtps_pkg::t_bound             ext;
    dtps_pkg::t_bound             lo_cl;
    dtps_pkg::t_bound             n_clamp;
    dtps_pkg::t_bound             r_clamp;
    logic                         r_vld;

    // |center - neighbor|; fits 31 bits whenever both depths are positive
    assign delta = {i_center_depth[dtps_pkg::DEPTH_W-1], i_center_depth}
                 - {i_nbr_depth[dtps_pkg::DEPTH_W-1], i_nbr_depth};
    assign mag   = delta[dtps_pkg::DEPTH_W] ? (~delta + 1'b1) : delta;

    always_ff @(posedge i_clk) begin
        if (i_en[dtps_pkg::STG_BND]) begin
            r_diff <= mag[dtps_pkg::THICK_W-1:0];
            r_nv   <= i_inside && (i_nbr_depth > 32'sd0);
        end
    end

    // Raise to lower bound first, then cap at upper (crossed bounds give upper)
    always_comb begin
        ext     = {{(dtps_pkg::BOUND_W - dtps_pkg::THICK_W){1'b0}}, r_diff};
        lo_cl   = (ext < i_lower) ? i_lower : ext;
        n_clamp = (lo_cl > i_upper) ? i_upper : lo_cl;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[dtps_pkg::STG_CLP]) begin
            r_clamp <= n_clamp;
            r_vld   <= r_nv;
        end
    end

    assign o_clamp = r_clamp;
    assign o_vld   = r_vld;

endmodule

// File: hdl/dtps_merge.sv
// Merge stage: registered adder tree over the lanes plus valid-neighbor count.
module dtps_merge (
    input  logic                          i_clk,
    input  dtps_pkg::t_stg_vec            i_en,
    input  dtps_pkg::t_bound              i_val [dtps_pkg::NUM_NB],
    input  logic [dtps_pkg::NUM_NB-1:0]   i_vld,
    output dtps_pkg::t_sum                o_sum,
    output dtps_pkg::t_cnt                o_cnt
);

    logic [dtps_pkg::SUM1_W-1:0] r_s1 [dtps_pkg::NUM_NB/2];
    logic [dtps_pkg::SUM2_W-1:0] r_s2 [dtps_pkg::NUM_NB/4];
    dtps_pkg::t_sum              r_sum;
    dtps_pkg::t_cnt              r_c1;
    dtps_pkg::t_cnt              r_c2;
    dtps_pkg::t_cnt              r_cnt;
    dtps_pkg::t_bound            masked [dtps_pkg::NUM_NB];

    // Lanes without a valid neighbor contribute zero
    always_comb begin
        for (int i = 0; i < dtps_pkg::NUM_NB; i++) begin
            masked[i] = i_vld[i] ? i_val[i] : '0;
        end
    end

    // First level: pairs of lanes
    always_ff @(posedge i_clk) begin
        if (i_en[dtps_pkg::STG_T1]) begin
            for (int j = 0; j < dtps_pkg::NUM_NB/2; j++) begin
                r_s1[j] <= dtps_pkg::SUM1_W'(masked[2*j]) + dtps_pkg::SUM1_W'(masked[2*j+1]);
            end
            r_c1 <= dtps_pkg::CNT_W'($countones(i_vld));
        end
    end

    // Second level
    always_ff @(posedge i_clk) begin
        if (i_en[dtps_pkg::STG_T2]) begin
            for (int j = 0; j < dtps_pkg::NUM_NB/4; j++) begin
                r_s2[j] <= dtps_pkg::SUM2_W'(r_s1[2*j]) + dtps_pkg::SUM2_W'(r_s1[2*j+1]);
            end
            r_c2 <= r_c1;
        end
    end

    // Final sum
    always_ff @(posedge i_clk) begin
        if (i_en[dtps_pkg::STG_SUM]) begin
            r_sum <= dtps_pkg::SUM_W'(r_s2[0]) + dtps_pkg::SUM_W'(r_s2[1]);
            r_cnt <= r_c2;
        end
    end

    assign o_sum = r_sum;
    assign o_cnt = r_cnt;

endmodule

// File: hdl/dtps_div.sv
// Pipelined divider of the neighbor sum by the small valid count, with saturation flag.
module dtps_div (
    input  logic               i_clk,
    input  dtps_pkg::t_stg_vec i_en,
    input  dtps_pkg::t_sum     i_sum,
    input  dtps_pkg::t_cnt     i_cnt,
    output dtps_pkg::t_thick   o_quot,
    output logic               o_sat
);

    dtps_pkg::t_div r_dv  [dtps_pkg::DIV_STG];
    dtps_pkg::t_cnt r_cnt [dtps_pkg::DIV_STG];
    logic           r_sat [dtps_pkg::DIV_STG];
    dtps_pkg::t_div dv_in;
    logic           sat_in;

    // Several restoring steps, one quotient bit each
    function automatic dtps_pkg::t_div div_steps(input dtps_pkg::t_div d,
                                                 input dtps_pkg::t_cnt cnt);
        dtps_pkg::t_div r;
        dtps_pkg::t_cnt t;
        logic           qb;
        r = d;
        for (int s = 0; s < dtps_pkg::DIV_BITS; s++) begin
            t = {r.rem, r.dq[dtps_pkg::DQ_W-1]};
            if (t >= cnt) begin
                t  = t - cnt;
                qb = 1'b1;
            end else begin
                qb = 1'b0;
            end
            r.rem = t[dtps_pkg::REM_W-1:0];
            r.dq  = {r.dq[dtps_pkg::DQ_W-2:0], qb};
        end
        return r;
    endfunction

    // Quotient overflows 31 bits exactly when sum >> 31 reaches the count
    assign sat_in = i_sum[dtps_pkg::SUM_W-1:dtps_pkg::THICK_W]
                    >= (dtps_pkg::SUM_W - dtps_pkg::THICK_W)'(i_cnt);
    assign dv_in  = '{rem: i_sum[dtps_pkg::DQ_W +: dtps_pkg::REM_W],
                      dq:  i_sum[dtps_pkg::DQ_W-1:0]};

    for (genvar j = 0; j < dtps_pkg::DIV_STG; j++) begin : g_stage
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en[dtps_pkg::STG_DIV0]) begin
                    r_dv[j]  <= div_steps(dv_in, i_cnt);
                    r_cnt[j] <= i_cnt;
                    r_sat[j] <= sat_in;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en[dtps_pkg::STG_DIV0 + j]) begin
                    r_dv[j]  <= div_steps(r_dv[j-1], r_cnt[j-1]);
                    r_cnt[j] <= r_cnt[j-1];
                    r_sat[j] <= r_sat[j-1];
                end
            end
        end
    end

    assign o_quot = r_dv[dtps_pkg::DIV_STG-1].dq[dtps_pkg::THICK_W-1:0];
    assign o_sat  = r_sat[dtps_pkg::DIV_STG-1];

endmodule

// File: hdl/depth_thickness_patch_smoother.sv
// Top level of the depth/thickness patch smoother: pipeline control, bounds and output.
// One pixel request enters per clock unless the output stalls, and passes 15 registers
// (input register, bound multiply and lane difference, lane clamp, three adder-tree
// levels, eight divider stages of four quotient bits each, output register) before its
// result is presented. The eight lanes, the two 16x31 bound multipliers and the
// pipelined divider all take a new request every cycle, so throughput is one pixel
// per clock while the output is not stalled. Every stage holds its request when the
// next one cannot load, so bubbles close up; while a finished result waits, input
// stays open until all 15 stages are full. The inflate registers reset to 1.0 and
// 4.0 (Q8.8) and should be written only while no request is in flight.
`include "depth_thickness_patch_smoother_defines.svh"

module depth_thickness_patch_smoother (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [15:0]               i_cfg_data,
    // pixel requests
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [31:0]        i_center_depth,
    input  logic [30:0]               i_center_thickness,
    input  logic signed [31:0]        i_depth_nw,
    input  logic signed [31:0]        i_depth_n,
    input  logic signed [31:0]        i_depth_ne,
    input  logic signed [31:0]        i_depth_w,
    input  logic signed [31:0]        i_depth_e,
    input  logic signed [31:0]        i_depth_sw,
    input  logic signed [31:0]        i_depth_s,
    input  logic signed [31:0]        i_depth_se,
    input  logic [7:0]                i_inside_mask,
    // results
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [30:0]               o_thickness_out,
    output logic                      o_was_updated
);

    dtps_pkg::t_inflate r_min_inf;
    dtps_pkg::t_inflate r_max_inf;

    dtps_pkg::t_stg_vec r_vld;
    dtps_pkg::t_stg_vec rdy;
    dtps_pkg::t_stg_vec vin;
    dtps_pkg::t_stg_vec en;

    dtps_pkg::t_depth               r_cdepth;
    dtps_pkg::t_depth               r_nbr [dtps_pkg::NUM_NB];
    logic [dtps_pkg::NUM_NB-1:0]    r_mask;
    dtps_pkg::t_thick               r_thk  [dtps_pkg::STG_IN:dtps_pkg::NUM_STG-1];
    logic                           r_flag [dtps_pkg::STG_BND:dtps_pkg::NUM_STG-1];

    logic [dtps_pkg::PROD_W-1:0]    prod_lo;
    logic [dtps_pkg::PROD_W-1:0]    prod_hi;
    dtps_pkg::t_bound               r_lower;
    dtps_pkg::t_bound               r_upper;

    dtps_pkg::t_bound               lane_clamp [dtps_pkg::NUM_NB];
    logic [dtps_pkg::NUM_NB-1:0]    lane_vld;
    dtps_pkg::t_sum                 sum;
    dtps_pkg::t_cnt                 cnt;
    dtps_pkg::t_thick               quot;
    logic                           sat;

    dtps_pkg::t_thick               r_thk_out;
    logic                           r_upd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_inf <= dtps_pkg::MIN_INFLATE_RESET;
            r_max_inf <= dtps_pkg::MAX_INFLATE_RESET;
        end else if (i_cfg_we) begin
            unique case (dtps_pkg::t_cfg_idx'(i_cfg_idx))
                dtps_pkg::CFG_MIN_INFLATE: r_min_inf <= i_cfg_data;
                dtps_pkg::CFG_MAX_INFLATE: r_max_inf <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ready chain: a stage loads when it is empty or its successor loads
    always_comb begin
        rdy[dtps_pkg::NUM_STG] = !r_vld[dtps_pkg::NUM_STG] || i_ready;
        for (int k = dtps_pkg::NUM_STG - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign vin = {r_vld[dtps_pkg::NUM_STG-1:1], i_valid};
    assign en  = rdy & vin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= dtps_pkg::NUM_STG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= vin[k];
                end
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (en[dtps_pkg::STG_IN]) begin
            r_cdepth                 <= i_center_depth;
            r_thk[dtps_pkg::STG_IN]  <= i_center_thickness;
            r_nbr[0]                 <= i_depth_nw;
            r_nbr[1]                 <= i_depth_n;
            r_nbr[2]                 <= i_depth_ne;
            r_nbr[3]                 <= i_depth_w;
            r_nbr[4]                 <= i_depth_e;
            r_nbr[5]                 <= i_depth_sw;
            r_nbr[6]                 <= i_depth_s;
            r_nbr[7]                 <= i_depth_se;
            r_mask                   <= i_inside_mask;
        end
    end

    // Clamp bounds from the center thickness
    assign prod_lo = dtps_pkg::PROD_W'(r_min_inf) * dtps_pkg::PROD_W'(r_thk[dtps_pkg::STG_IN]);
    assign prod_hi = dtps_pkg::PROD_W'(r_max_inf) * dtps_pkg::PROD_W'(r_thk[dtps_pkg::STG_IN]);

    always_ff @(posedge i_clk) begin
        if (en[dtps_pkg::STG_BND]) begin
            r_lower                   <= prod_lo[dtps_pkg::PROD_W-1:dtps_pkg::INF_FRAC];
            r_upper                   <= prod_hi[dtps_pkg::PROD_W-1:dtps_pkg::INF_FRAC];
            r_thk[dtps_pkg::STG_BND]  <= r_thk[dtps_pkg::STG_IN];
            r_flag[dtps_pkg::STG_BND] <= (r_cdepth > 32'sd0);
        end
    end

    // Sideband: pass-through thickness and update flag follow the request
    for (genvar k = dtps_pkg::STG_CLP; k < dtps_pkg::NUM_STG; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_thk[k] <= r_thk[k-1];
                if (k == dtps_pkg::STG_DIV0) begin
                    r_flag[k] <= r_flag[k-1] && (cnt >= dtps_pkg::MIN_VALID_CNT);
                end else begin
                    r_flag[k] <= r_flag[k-1];
                end
            end
        end
    end

    // Neighbor lanes
    for (genvar i = 0; i < dtps_pkg::NUM_NB; i++) begin : g_lane
        dtps_lane u_lane (
            .i_clk          (i_clk),
            .i_en           (en),
            .i_center_depth (r_cdepth),
            .i_nbr_depth    (r_nbr[i]),
            .i_inside       (r_mask[i]),
            .i_lower        (r_lower),
            .i_upper        (r_upper),
            .o_clamp        (lane_clamp[i]),
            .o_vld          (lane_vld[i])
        );
    end

    dtps_merge u_merge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_val (lane_clamp),
        .i_vld (lane_vld),
        .o_sum (sum),
        .o_cnt (cnt)
    );

    dtps_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (sum),
        .i_cnt  (cnt),
        .o_quot (quot),
        .o_sat  (sat)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (en[dtps_pkg::STG_OUT]) begin
            if (r_flag[dtps_pkg::STG_OUT-1]) begin
                r_thk_out <= sat ? dtps_pkg::THICK_MAX : quot;
            end else begin
                r_thk_out <= r_thk[dtps_pkg::STG_OUT-1];
            end
            r_upd <= r_flag[dtps_pkg::STG_OUT-1];
        end
    end

    assign o_ready         = rdy[dtps_pkg::STG_IN];
    assign o_valid         = r_vld[dtps_pkg::STG_OUT];
    assign o_thickness_out = r_thk_out;
    assign o_was_updated   = r_upd;

    // Input closes only when every stage is full and the output is stalled
    `DTPS_ASSERT_IMPL(a_ready_full, i_clk, i_rst_n, !o_ready, (&r_vld) && !i_ready, "ready low with room in pipeline")

    // A taken result with nothing behind it leaves the output empty
    `DTPS_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_valid && i_ready && !r_vld[dtps_pkg::STG_OUT-1], !o_valid, "output valid without a request")

    // A stalled input stage keeps its request
    `DTPS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_vld[dtps_pkg::STG_IN] && !rdy[dtps_pkg::STG_IN], r_vld[dtps_pkg::STG_IN] && $stable(r_cdepth), "stalled input stage lost its request")

endmodule

// File: test/dtps_result_check.sv
// Request/result monitor for the depth/thickness smoother: predicts and compares results.
module dtps_result_check
    import dtps_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_idx,
    input  t_inflate                         i_cfg_data,
    // pixel requests
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  t_depth                           i_center_depth,
    input  t_thick                           i_center_thickness,
    input  logic [NUM_NB-1:0][DEPTH_W-1:0]   i_nb_depth,
    input  logic [7:0]                       i_inside_mask,
    // results
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  t_thick                           i_thickness_out,
    input  logic                             i_was_updated,
    // status for the top
    output int                               o_mismatches,
    output int                               o_pending
);

    typedef struct packed {
        t_thick thick;
        logic   updated;
    } t_smooth;

    t_inflate lo_inflate;
    t_inflate hi_inflate;
    t_smooth  smooth_q[$];
    int       mismatch_total;

    // Clamp each valid neighbour difference into the inflated thickness window, then average
    function automatic t_smooth smooth_pixel(input t_depth cd, input t_thick ct,
                                             input logic [NUM_NB-1:0][DEPTH_W-1:0] nbd,
                                             input logic [7:0] mask,
                                             input t_inflate lo_f, input t_inflate hi_f);
        t_smooth    r;
        longint     centre;
        longint     nd;
        bit [63:0]  lower;
        bit [63:0]  upper;
        bit [63:0]  diff;
        bit [63:0]  sum;
        bit [63:0]  mean;
        int         count;
        r.thick   = ct;
        r.updated = 1'b0;
        centre    = cd;
        if (centre <= 0)
            return r;
        lower = (64'(lo_f) * 64'(ct)) >> INF_FRAC;
        upper = (64'(hi_f) * 64'(ct)) >> INF_FRAC;
        sum   = '0;
        count = 0;
        for (int i = 0; i < NUM_NB; i++) begin
            nd = t_depth'(nbd[i]);
            if (!mask[i] || nd <= 0)
                continue;
            diff = (centre >= nd) ? centre - nd : nd - centre;
            if (diff < lower)
                diff = lower;
            // crossed window ends at the upper bound
            if (diff > upper)
                diff = upper;
            sum += diff;
            count++;
        end
        if (count < MIN_VALID)
            return r;
        mean = sum / 64'(count);
        if (mean > 64'(THICK_MAX))
            mean = 64'(THICK_MAX);
        r.thick   = mean[THICK_W-1:0];
        r.updated = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_smooth want;
        if (!i_rst_n) begin
            lo_inflate = MIN_INFLATE_RESET;
            hi_inflate = MAX_INFLATE_RESET;
            smooth_q.delete();
        end else begin
            // shadow copy of the inflate registers
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_INFLATE: lo_inflate = i_cfg_data;
                    CFG_MAX_INFLATE: hi_inflate = i_cfg_data;
                    default: ;
                endcase
            end
            // accepted request: queue its prediction
            if (i_req_valid && i_req_ready)
                smooth_q.push_back(smooth_pixel(i_center_depth, i_center_thickness,
                                                i_nb_depth, i_inside_mask,
                                                lo_inflate, hi_inflate));
            // accepted result: compare with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                if (smooth_q.size() == 0) begin
                    if (mismatch_total < 10)
                        $display("unexpected result: thickness %0d updated %0b",
                                 i_thickness_out, i_was_updated);
                    mismatch_total++;
                end else begin
                    want = smooth_q.pop_front();
                    if (want.thick !== i_thickness_out || want.updated !== i_was_updated) begin
                        if (mismatch_total < 10)
                            $display("bad result: thickness exp %0d got %0d, updated exp %0b got %0b",
                                     want.thick, i_thickness_out, want.updated, i_was_updated);
                        mismatch_total++;
                    end
                end
            end
        end
        o_pending    <= smooth_q.size();
        o_mismatches <= mismatch_total;
    end

endmodule

// File: test/testbench.sv
// Top of the depth/thickness smoother testbench: clock, reset, stimulus and verdict.
module testbench;
    import dtps_pkg::*;

    typedef struct packed {
        t_depth                           center_depth;
        t_thick                           center_thickness;
        logic [NUM_NB-1:0][DEPTH_W-1:0]   nb;
        logic [7:0]                       mask;
    } t_pixel;

    localparam int       PHASE_ITEMS = 90;
    localparam t_inflate LO_SETS [4] = '{16'd0, 16'd65535, 16'd1024, 16'd64};
    localparam t_inflate HI_SETS [4] = '{16'd0, 16'd65535, 16'd256, 16'd768};

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    t_cfg_idx                         cfg_idx;
    t_inflate                         cfg_data;
    logic                             pix_valid;
    logic                             pix_ready;
    t_depth                           pix_center_depth;
    t_thick                           pix_center_thickness;
    logic [NUM_NB-1:0][DEPTH_W-1:0]   pix_nb;
    logic [7:0]                       pix_mask;
    logic                             res_valid;
    logic                             res_ready;
    t_thick                           res_thickness;
    logic                             res_updated;
    int                               mismatches;
    int                               pending;
    bit                               tx_quiet;
    bit                               rx_quiet;
    int                               rx_wait;

    depth_thickness_patch_smoother dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_valid            (pix_valid),
        .o_ready            (pix_ready),
        .i_center_depth     (pix_center_depth),
        .i_center_thickness (pix_center_thickness),
        .i_depth_nw         (pix_nb[0]),
        .i_depth_n          (pix_nb[1]),
        .i_depth_ne         (pix_nb[2]),
        .i_depth_w          (pix_nb[3]),
        .i_depth_e          (pix_nb[4]),
        .i_depth_sw         (pix_nb[5]),
        .i_depth_s          (pix_nb[6]),
        .i_depth_se         (pix_nb[7]),
        .i_inside_mask      (pix_mask),
        .o_valid            (res_valid),
        .i_ready            (res_ready),
        .o_thickness_out    (res_thickness),
        .o_was_updated      (res_updated)
    );

    dtps_result_check smooth_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_req_valid        (pix_valid),
        .i_req_ready        (pix_ready),
        .i_center_depth     (pix_center_depth),
        .i_center_thickness (pix_center_thickness),
        .i_nb_depth         (pix_nb),
        .i_inside_mask      (pix_mask),
        .i_res_valid        (res_valid),
        .i_res_ready        (res_ready),
        .i_thickness_out    (res_thickness),
        .i_was_updated      (res_updated),
        .o_mismatches       (mismatches),
        .o_pending          (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Result side: after each accepted result, draw a random stall (none while rx_quiet is set)
    always @(posedge clk) begin : result_sink
        int draw;
        if (!rst_n) begin
            res_ready <= 1'b0;
            rx_wait   <= 0;
        end else if (rx_wait > 0) begin
            rx_wait   <= rx_wait - 1;
            res_ready <= (rx_wait == 1);
        end else if (res_ready && res_valid) begin
            draw      = rx_quiet ? 0 : $urandom_range(0, 10);
            rx_wait   <= draw;
            res_ready <= (draw == 0);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // All eight neighbours at one depth
    function automatic t_pixel flat_patch(input t_depth cd, input t_thick ct,
                                          input t_depth nd, input logic [7:0] mask);
        t_pixel p;
        p.center_depth     = cd;
        p.center_thickness = ct;
        for (int i = 0; i < NUM_NB; i++)
            p.nb[i] = nd;
        p.mask = mask;
        return p;
    endfunction

    // Mostly coherent patches around a positive centre, the rest raw noise
    function automatic t_pixel random_pixel();
        t_pixel      p;
        int unsigned spread;
        longint      c;
        longint      n;
        if ($urandom_range(0, 99) < 20) begin
            p.center_depth     = $urandom;
            p.center_thickness = 31'($urandom);
            for (int i = 0; i < NUM_NB; i++)
                p.nb[i] = $urandom;
            p.mask = 8'($urandom);
            return p;
        end
        spread = 32'd1 << $urandom_range(0, 30);
        c = $urandom_range(1, 32'h7FFF_FFFF);
        if ($urandom_range(0, 1))
            c = $urandom_range(1, spread);
        p.center_depth = c[31:0];
        for (int i = 0; i < NUM_NB; i++) begin
            n = c + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
            if (n > 2147483647)
                n = 2147483647;
            if ($urandom_range(0, 9) == 0)
                n = -longint'($urandom_range(0, 32'h8000_0000));
            p.nb[i] = n[31:0];
        end
        case ($urandom_range(0, 3))
            0:       p.center_thickness = 31'($urandom);
            1:       p.center_thickness = '0;
            default: p.center_thickness = 31'($urandom_range(0, spread));
        endcase
        p.mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        return p;
    endfunction

    // Present one pixel request and hold it until accepted
    task automatic send_pixel(input t_pixel p);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid            <= 1'b1;
        pix_center_depth     <= p.center_depth;
        pix_center_thickness <= p.center_thickness;
        pix_nb               <= p.nb;
        pix_mask             <= p.mask;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
    endtask

    // Stop requests and wait until every predicted result has come back
    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_inflate(input t_cfg_idx idx, input t_inflate value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        t_pixel p;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_MIN_INFLATE;
        cfg_data             = '0;
        pix_valid            = 1'b0;
        pix_center_depth     = '0;
        pix_center_thickness = '0;
        pix_nb               = '0;
        pix_mask             = '0;
        tx_quiet             = 1'b0;
        rx_quiet             = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: invalid centre (zero, most negative, minus one)
        send_pixel(flat_patch(0, 31'd1000, 32'd4096, 8'hFF));
        send_pixel(flat_patch(32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 8'hFF));
        send_pixel(flat_patch(-1, 31'd5, 32'd100, 8'hFF));
        // too few neighbours: empty mask, two inside, non-positive depths
        send_pixel(flat_patch(32'd4096, 31'd2000, 32'd5000, 8'h00));
        send_pixel(flat_patch(32'd4096, 31'd2000, 32'd5000, 8'h81));
        p = flat_patch(32'd4096, 31'd2000, 32'd5000, 8'hFF);
        p.nb[0] = '0;
        p.nb[1] = -1;
        p.nb[2] = 32'h8000_0000;
        p.nb[3] = -32'sd4096;
        p.nb[4] = '0;
        p.nb[5] = -32'sd7;
        send_pixel(p);
        // three inside, rotating over every mask bit, diffs on both sides of the window
        for (int k = 0; k < NUM_NB; k++) begin
            p = flat_patch(32'd4096, 31'd400, 32'd0, 8'((8'h07 << k) | (8'h07 >> (8 - k))));
            for (int i = 0; i < NUM_NB; i++)
                p.nb[i] = 32'd3000 + 32'(i * 450);
            send_pixel(p);
        end
        // zero thickness, extreme depths, window limits
        send_pixel(flat_patch(32'd10000, 31'd0, 32'd20000, 8'hFF));
        send_pixel(flat_patch(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'd1, 8'hFF));
        send_pixel(flat_patch(32'd1, 31'd1, 32'sh7FFF_FFFF, 8'hFF));
        send_pixel(flat_patch(32'd1, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 8'hFF));

        // Random phases: reset inflates first, then zero, full scale, crossed, mid, random
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                settle();
                write_inflate(CFG_MIN_INFLATE, (ph == 5) ? 16'($urandom) : LO_SETS[ph-1]);
                write_inflate(CFG_MAX_INFLATE, (ph == 5) ? 16'($urandom) : HI_SETS[ph-1]);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 30 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet <= ($urandom_range(0, 3) == 0);
                end
                send_pixel(random_pixel());
            end
        end

        settle();
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #1600000;
        $display("Mismatches found");
        $finish;
    end

endmodule
